@@ src/esv_pkg.sv @@
package esv_pkg;

   // Default width of the modulus and of every configuration register.
   localparam int MOD_BITS_DEFAULT = 16;

   // Width of the message and signature fields of a request beat.
   localparam int FIELD_BITS = 16;

   // Configuration register file.
   localparam int CSR_INDEX_BITS = 2;

   localparam int MODULUS_RESET    = 23;
   localparam int GENERATOR_RESET  = 5;
   localparam int PUBLIC_KEY_RESET = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS    = 2'd0,
      CSR_GENERATOR  = 2'd1,
      CSR_PUBLIC_KEY = 2'd2
   } csr_index_type;

   // Which of the three powers is being computed.
   typedef enum logic [1:0] {
      POW_KEY, // public_key ^ sig_r
      POW_SIG, // sig_r ^ sig_s
      POW_GEN  // generator ^ message
   } pow_sel_type;

   // Operand pair loaded into the multiplier.
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_ACC,  // acc * base
      MUL_SQR,  // base * base
      MUL_LEFT  // acc * hold
   } mul_sel_type;

   // Destination of a finished reduction.
   typedef enum logic [2:0] {
      WB_NONE,
      WB_BASE,
      WB_ACC,
      WB_SQR,
      WB_LEFT
   } wb_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE,
      ST_RED,
      ST_WB,
      ST_TEST,
      ST_MUL_ACC,
      ST_MUL_SQR,
      ST_POW_END,
      ST_MUL_LEFT,
      ST_DONE
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        load_base;
      pow_sel_type pow_sel;
      mul_sel_type mul_sel;
      logic        red_step;
      wb_sel_type  wb_sel;
      logic        save_hold;
      logic        out_load;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic p_small;
      logic red_last;
      logic exp_zero;
      logic exp_lsb;
      logic exp_high_zero;
   } dp_status_type;

endpackage

@@ src/esv_req_if.sv @@
interface esv_req_if;
   import esv_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] message;
   logic [FIELD_BITS-1:0] sig_r;
   logic [FIELD_BITS-1:0] sig_s;

   modport source (output valid, output message, output sig_r, output sig_s, input ready);
   modport sink (input valid, input message, input sig_r, input sig_s, output ready);
endinterface

@@ src/esv_rsp_if.sv @@
interface esv_rsp_if #(
   parameter int MOD_BITS = esv_pkg::MOD_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic                valid_res;
   logic [MOD_BITS-1:0] left_value;
   logic [MOD_BITS-1:0] right_value;

   modport source (output valid, output valid_res, output left_value, output right_value,
                   input ready);
   modport sink (input valid, input valid_res, input left_value, input right_value,
                 output ready);
endinterface

@@ src/esv_datapath.sv @@
module esv_datapath #(
   parameter int MOD_BITS = esv_pkg::MOD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [esv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [MOD_BITS-1:0]                 csr_wdata,
   input  logic [esv_pkg::FIELD_BITS-1:0]      message,
   input  logic [esv_pkg::FIELD_BITS-1:0]      sig_r,
   input  logic [esv_pkg::FIELD_BITS-1:0]      sig_s,
   input  esv_pkg::ctl_cmd_type                cmd,
   output esv_pkg::dp_status_type              status,
   output logic                                valid_res,
   output logic [MOD_BITS-1:0]                 left_value,
   output logic [MOD_BITS-1:0]                 right_value
);
   import esv_pkg::*;

   // The product register must hold a full product and an unreduced signature value.
   localparam int PROD_BITS = (2 * MOD_BITS > FIELD_BITS) ? 2 * MOD_BITS : FIELD_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);

   logic [MOD_BITS-1:0]   modulus_ff;
   logic [MOD_BITS-1:0]   generator_ff;
   logic [MOD_BITS-1:0]   public_key_ff;
   logic [FIELD_BITS-1:0] message_ff;
   logic [FIELD_BITS-1:0] sig_r_ff;
   logic [FIELD_BITS-1:0] sig_s_ff;
   logic [FIELD_BITS-1:0] exp_ff;
   logic [MOD_BITS-1:0]   base_ff;
   logic [MOD_BITS-1:0]   acc_ff;
   logic [MOD_BITS-1:0]   hold_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [PROD_BITS-1:0]  prod_in;
   logic [MOD_BITS-1:0]   rem_ff;
   logic [MOD_BITS-1:0]   rem_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  res_ok_ff;
   logic [MOD_BITS-1:0]   res_left_ff;
   logic [MOD_BITS-1:0]   res_right_ff;
   logic [MOD_BITS-1:0]   mul_a;
   logic [MOD_BITS-1:0]   mul_b;
   logic [2*MOD_BITS-1:0] mul_prod;
   logic [MOD_BITS:0]     trial;
   logic [FIELD_BITS-1:0] exp_src;
   logic                  p_small;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= MOD_BITS'(MODULUS_RESET);
         generator_ff  <= MOD_BITS'(GENERATOR_RESET);
         public_key_ff <= MOD_BITS'(PUBLIC_KEY_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            CSR_GENERATOR:  generator_ff  <= csr_wdata;
            CSR_PUBLIC_KEY: public_key_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign p_small = (modulus_ff[MOD_BITS-1:1] == '0);

   // Multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         MUL_SQR: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         MUL_LEFT: begin
            mul_a = acc_ff;
            mul_b = hold_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // Value loaded into the product register: a base to reduce or a fresh product.
   always_comb begin
      prod_in = PROD_BITS'(mul_prod);
      exp_src = sig_r_ff;
      if (cmd.load_base) begin
         case (cmd.pow_sel)
            POW_SIG: begin
               prod_in = PROD_BITS'(sig_r_ff);
               exp_src = sig_s_ff;
            end
            POW_GEN: begin
               prod_in = PROD_BITS'(generator_ff);
               exp_src = message_ff;
            end
            default: begin
               prod_in = PROD_BITS'(public_key_ff);
               exp_src = sig_r_ff;
            end
         endcase
      end
   end

   // One restoring step of the reduction: shift in the next product bit, subtract p if it fits.
   assign trial  = {rem_ff, prod_ff[PROD_BITS-1]};
   assign rem_in = (trial >= {1'b0, modulus_ff}) ? MOD_BITS'(trial - {1'b0, modulus_ff})
                                                  : MOD_BITS'(trial);

   // Reduction unit: product register, remainder and bit counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load_base || cmd.mul_sel != MUL_NONE) begin
         cnt_ff <= '0;
      end else if (cmd.red_step) begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_base || cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
         rem_ff  <= '0;
      end else if (cmd.red_step) begin
         prod_ff <= {prod_ff[PROD_BITS-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
   end

   // Request capture and exponentiation registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         message_ff <= message;
         sig_r_ff   <= sig_r;
         sig_s_ff   <= sig_s;
      end
      if (cmd.load_base) begin
         exp_ff <= exp_src;
         acc_ff <= MOD_BITS'(1);
      end
      case (cmd.wb_sel)
         WB_BASE: base_ff <= rem_ff;
         WB_ACC:  acc_ff  <= rem_ff;
         WB_SQR: begin
            base_ff <= rem_ff;
            exp_ff  <= exp_ff >> 1;
         end
         WB_LEFT: hold_ff <= rem_ff;
         default: ;
      endcase
      if (cmd.save_hold) begin
         hold_ff <= acc_ff;
      end
   end

   // Result register: hold carries the left side, acc the right side.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_ok_ff    <= !p_small && (hold_ff == acc_ff);
         res_left_ff  <= p_small ? '0 : hold_ff;
         res_right_ff <= p_small ? '0 : acc_ff;
      end
   end

   assign status.p_small       = p_small;
   assign status.red_last      = (cnt_ff == CNT_BITS'(PROD_BITS - 1));
   assign status.exp_zero      = (exp_ff == '0);
   assign status.exp_lsb       = exp_ff[0];
   assign status.exp_high_zero = (exp_ff[FIELD_BITS-1:1] == '0);

   assign valid_res   = res_ok_ff;
   assign left_value  = res_left_ff;
   assign right_value = res_right_ff;

endmodule

@@ src/esv_controller.sv @@
module esv_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  esv_pkg::dp_status_type status,
   output esv_pkg::ctl_cmd_type   cmd
);
   import esv_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   pow_sel_type   pow_ff;
   pow_sel_type   pow_in;
   wb_sel_type    wb_sel_ff;
   wb_sel_type    wb_sel_in;
   logic          out_valid_ff;
   logic          out_valid_in;

   // State and sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pow_ff       <= POW_KEY;
         wb_sel_ff    <= WB_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pow_ff       <= pow_in;
         wb_sel_ff    <= wb_sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      pow_in        = pow_ff;
      wb_sel_in     = wb_sel_ff;
      cmd           = '{capture: 1'b0, load_base: 1'b0, pow_sel: pow_ff, mul_sel: MUL_NONE,
                        red_step: 1'b0, wb_sel: WB_NONE, save_hold: 1'b0, out_load: 1'b0};
      req_ready     = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               pow_in      = POW_KEY;
               state_in    = status.p_small ? ST_DONE : ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.load_base = 1'b1;
            wb_sel_in     = WB_BASE;
            state_in      = ST_RED;
         end
         ST_RED: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            cmd.wb_sel = wb_sel_ff;
            case (wb_sel_ff)
               WB_ACC:  state_in = status.exp_high_zero ? ST_POW_END : ST_MUL_SQR;
               WB_LEFT: begin
                  pow_in   = POW_GEN;
                  state_in = ST_BASE;
               end
               default: state_in = ST_TEST;
            endcase
         end
         ST_TEST: begin
            if (status.exp_zero) begin
               state_in = ST_POW_END;
            end else if (status.exp_lsb) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_MUL_SQR;
            end
         end
         ST_MUL_ACC: begin
            cmd.mul_sel = MUL_ACC;
            wb_sel_in   = WB_ACC;
            state_in    = ST_RED;
         end
         ST_MUL_SQR: begin
            cmd.mul_sel = MUL_SQR;
            wb_sel_in   = WB_SQR;
            state_in    = ST_RED;
         end
         ST_POW_END: begin
            case (pow_ff)
               POW_KEY: begin
                  cmd.save_hold = 1'b1;
                  pow_in        = POW_SIG;
                  state_in      = ST_BASE;
               end
               POW_SIG: state_in = ST_MUL_LEFT;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL_LEFT: begin
            cmd.mul_sel = MUL_LEFT;
            wb_sel_in   = WB_LEFT;
            state_in    = ST_RED;
         end
         ST_DONE: begin
            // Wait until the result register is free or being emptied this cycle.
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ src/elgamal_signature_verify.sv @@
// ElGamal signature verifier. Program modulus p, generator g and public key y through the
// csr_ port while the block is idle; each request beat (message m, sig_r, sig_s) then yields
// one response beat with left_value = y^r * r^s mod p, right_value = g^m mod p and valid_res
// set when they match. A modulus below two gives zeros and valid_res low. All arithmetic goes
// through one multiplier followed by a bit-serial reducer over a product register of
// P = max(2*MOD_BITS, 16) bits. An item needs three base reductions, one squaring per
// exponent bit below the top set bit, one product per set exponent bit and one final
// product: up to about 100 products, fewer for short or sparse exponents. One item is in
// flight at a time; the next request is taken as soon as the previous result sits in the
// response register.
module elgamal_signature_verify #(
   parameter int MOD_BITS = esv_pkg::MOD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   esv_req_if.sink                            req_chan,
   esv_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_en,
   input  logic [esv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [MOD_BITS-1:0]                csr_wdata
);
   import esv_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // Sequencer for the three exponentiations and the final product.
   esv_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Configuration, multiplier, reducer and result register.
   esv_datapath #(
      .MOD_BITS (MOD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .message      (req_chan.message),
      .sig_r        (req_chan.sig_r),
      .sig_s        (req_chan.sig_s),
      .cmd          (cmd),
      .status       (status),
      .valid_res    (rsp_chan.valid_res),
      .left_value   (rsp_chan.left_value),
      .right_value  (rsp_chan.right_value)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // Once a beat is taken the block is busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted twice in a row");

   // A positive verdict always carries two equal values.
   a_verdict_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.valid_res) |-> (rsp_chan.left_value == rsp_chan.right_value))
      else $error("valid_res set with differing values");

   // The result register is never overwritten while a beat is still pending.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten");

   // Datapath commands that load the reducer never coincide with a reduction step.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.red_step |-> (!cmd.load_base && cmd.mul_sel == MUL_NONE))
      else $error("reducer loaded during a reduction step");

endmodule
